// ----- rtl/hftq_pkg.sv -----
// Shared types and constants of the height-field triangle height query block.
package hftq_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int FRAC_BITS   = 24;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int CNT_W       = 8;
  localparam int ENTRY_W     = 7;
  localparam int POS_W       = 24;
  localparam int HALF_W      = 23;
  localparam int INV_W       = 24;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 3;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Depths of the command queue and of the result queue.
  localparam int CMD_DEPTH = 8;
  localparam int RES_DEPTH = 4;

  // Request modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SPACING = 3'd4;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]  NUM_COLUMNS_RESET      = 8'd128;
  localparam logic [CNT_W-1:0]  NUM_ROWS_RESET         = 8'd128;
  localparam logic [HALF_W-1:0] HALF_WIDTH_RESET       = '0;
  localparam logic [HALF_W-1:0] HALF_LENGTH_RESET      = '0;
  localparam logic [INV_W-1:0]  INV_CELL_SPACING_RESET = 24'd65536;

  typedef struct packed {
    logic                     mode;
    logic [ENTRY_W-1:0]       entry_column;
    logic [ENTRY_W-1:0]       entry_row;
    logic [HEIGHT_BITS-1:0]   entry_height;
    logic signed [POS_W-1:0]  query_x;
    logic signed [POS_W-1:0]  query_z;
  } req_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic                   out_of_range;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]  num_columns;
    logic [CNT_W-1:0]  num_rows;
    logic [HALF_W-1:0] half_width;
    logic [HALF_W-1:0] half_length;
    logic [INV_W-1:0]  inv_cell_spacing;
  } cfg_t;

  // One classified request on its way from the front end to the back end.
  typedef struct packed {
    logic                   is_query;
    logic                   keep;
    logic [CNT_W-1:0]       col;
    logic [CNT_W-1:0]       row;
    logic [FRAC_W-1:0]      fx;
    logic [FRAC_W-1:0]      fz;
    logic                   clamped;
    logic [HEIGHT_BITS-1:0] wdata;
  } cmd_t;

  // Four corner heights and the position inside the quad.
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] a;
    logic [HEIGHT_BITS-1:0] b;
    logic [HEIGHT_BITS-1:0] c;
    logic [HEIGHT_BITS-1:0] d;
    logic [FRAC_W-1:0]      fx;
    logic [FRAC_W-1:0]      fz;
    logic                   clamped;
  } quad_t;

endpackage

// ----- rtl/hftq_fifo.sv -----
// Small register queue used for commands and for results.
module hftq_fifo #(
  parameter int DEPTH = 4,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- rtl/hftq_front.sv -----
// Front end: takes requests, maps query positions to grid cells and fractions.
module hftq_front #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  hftq_pkg::cfg_t cfg,
  input  logic          req_valid,
  output logic          req_stall,
  input  hftq_pkg::req_t req_data,
  output logic          cmd_push,
  output hftq_pkg::cmd_t cmd_data,
  input  logic          cmd_pop
);

  localparam int CNT_W  = hftq_pkg::CNT_W;
  localparam int FB     = hftq_pkg::FRAC_BITS;
  localparam int FW     = hftq_pkg::FRAC_W;
  localparam int SUM_W  = hftq_pkg::POS_W + 1;
  localparam int P_W    = SUM_W + hftq_pkg::INV_W + 1;
  localparam int HELD_W = $clog2(hftq_pkg::CMD_DEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0] cell_idx;
    logic [FW-1:0]    frac;
    logic             clamped;
  } loc_t;

  // Clamp a grid coordinate with FB fraction bits to the cells in use.
  function automatic loc_t locate(input logic signed [P_W-1:0] p,
                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0]      last;
    logic signed [P_W-1:0] top;
    loc_t                  r;
    last = cnt - CNT_W'(1);
    top  = $signed({{(P_W - CNT_W - FB){1'b0}}, last, {FB{1'b0}}});
    if (p < 0) begin
      r.cell_idx = '0;
      r.frac     = '0;
      r.clamped  = 1'b1;
    end else if (p > top) begin
      r.cell_idx = cnt - CNT_W'(2);
      r.frac     = hftq_pkg::FRAC_ONE;
      r.clamped  = 1'b1;
    end else if (p[FB+CNT_W-1:FB] == last) begin
      r.cell_idx = cnt - CNT_W'(2);
      r.frac     = hftq_pkg::FRAC_ONE;
      r.clamped  = 1'b0;
    end else begin
      r.cell_idx = p[FB+CNT_W-1:FB];
      r.frac     = {1'b0, p[FB-1:0]};
      r.clamped  = 1'b0;
    end
    return r;
  endfunction

  logic [HELD_W-1:0]       held;
  logic                    accept;

  logic                    s1_valid;
  hftq_pkg::req_t          s1_req;
  logic signed [SUM_W-1:0] s1_sx;
  logic signed [SUM_W-1:0] s1_sz;

  logic                    s2_valid;
  hftq_pkg::req_t          s2_req;
  logic signed [P_W-1:0]   s2_px;
  logic signed [P_W-1:0]   s2_pz;

  logic [CNT_W-1:0]        ncol;
  logic [CNT_W-1:0]        nrow;
  loc_t                    loc_x;
  loc_t                    loc_z;

  // Items in the two stages plus items in the queue never exceed its depth.
  assign req_stall = (held == HELD_W'(hftq_pkg::CMD_DEPTH));
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      held     <= held + HELD_W'(accept) - HELD_W'(cmd_pop);
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_req <= req_data;
    s1_sx  <= $signed({req_data.query_x[hftq_pkg::POS_W-1], req_data.query_x})
            + $signed({2'b00, cfg.half_width});
    s1_sz  <= $signed({req_data.query_z[hftq_pkg::POS_W-1], req_data.query_z})
            + $signed({2'b00, cfg.half_length});
    s2_req <= s1_req;
    s2_px  <= s1_sx * $signed({1'b0, cfg.inv_cell_spacing});
    s2_pz  <= s1_sz * $signed({1'b0, cfg.inv_cell_spacing});
  end

  always_comb begin
    ncol = cfg.num_columns;
    if (cfg.num_columns < CNT_W'(2)) begin
      ncol = CNT_W'(2);
    end else if (int'(cfg.num_columns) > MAX_COLUMNS) begin
      ncol = CNT_W'(MAX_COLUMNS);
    end
    nrow = cfg.num_rows;
    if (cfg.num_rows < CNT_W'(2)) begin
      nrow = CNT_W'(2);
    end else if (int'(cfg.num_rows) > MAX_ROWS) begin
      nrow = CNT_W'(MAX_ROWS);
    end
  end

  always_comb begin
    loc_x    = locate(s2_px, ncol);
    loc_z    = locate(s2_pz, nrow);
    cmd_data = '0;
    if (s2_req.mode == hftq_pkg::MODE_QUERY) begin
      cmd_data.is_query = 1'b1;
      cmd_data.keep     = 1'b1;
      cmd_data.col      = loc_x.cell_idx;
      cmd_data.row      = loc_z.cell_idx;
      cmd_data.fx       = loc_x.frac;
      cmd_data.fz       = loc_z.frac;
      cmd_data.clamped  = loc_x.clamped | loc_z.clamped;
    end else begin
      cmd_data.is_query = 1'b0;
      cmd_data.keep     = (int'(s2_req.entry_column) < MAX_COLUMNS)
                       && (int'(s2_req.entry_row) < MAX_ROWS);
      cmd_data.col      = {1'b0, s2_req.entry_column};
      cmd_data.row      = {1'b0, s2_req.entry_row};
      cmd_data.wdata    = s2_req.entry_height;
    end
  end

  assign cmd_push = s2_valid;

endmodule

// ----- rtl/hftq_interp.sv -----
// Triangle interpolation pipeline with round-half-up and saturation.
module hftq_interp (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hftq_pkg::quad_t in_quad,
  output logic            out_valid,
  output hftq_pkg::res_t  out_res
);

  localparam int HB     = hftq_pkg::HEIGHT_BITS;
  localparam int FB     = hftq_pkg::FRAC_BITS;
  localparam int FW     = hftq_pkg::FRAC_W;
  localparam int DIFF_W = HB + 1;
  localparam int PROD_W = FW + 1 + DIFF_W;
  localparam int SUM_W  = HB + FB + 4;
  localparam int Q_W    = SUM_W - FB;
  localparam logic [SUM_W-1:0] ROUND_HALF = {{(SUM_W - FB){1'b0}}, 1'b1, {(FB - 1){1'b0}}};

  logic                     upper;
  logic signed [DIFF_W-1:0] ha, hb, hc, hd;

  logic                     m0_valid;
  logic [FW-1:0]            m0_w1, m0_w2;
  logic signed [DIFF_W-1:0] m0_d1, m0_d2;
  logic [HB-1:0]            m0_base;
  logic                     m0_clamped;

  logic                     m1_valid;
  logic signed [PROD_W-1:0] m1_p1, m1_p2;
  logic [HB-1:0]            m1_base;
  logic                     m1_clamped;

  logic                     m2_valid;
  logic signed [SUM_W-1:0]  m2_sum;
  logic                     m2_clamped;

  logic signed [SUM_W-1:0]  rounded;
  logic [Q_W-1:0]           quot;

  assign ha    = $signed({1'b0, in_quad.a});
  assign hb    = $signed({1'b0, in_quad.b});
  assign hc    = $signed({1'b0, in_quad.c});
  assign hd    = $signed({1'b0, in_quad.d});
  // The diagonal runs from A to D; fx < fz puts the point in the triangle A, C, D.
  assign upper = in_quad.fx < in_quad.fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m0_valid <= in_valid;
      m1_valid <= m0_valid;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upper) begin
      m0_base <= in_quad.c;
      m0_w1   <= in_quad.fx;
      m0_d1   <= hd - hc;
      m0_w2   <= hftq_pkg::FRAC_ONE - in_quad.fz;
      m0_d2   <= ha - hc;
    end else begin
      m0_base <= in_quad.b;
      m0_w1   <= hftq_pkg::FRAC_ONE - in_quad.fx;
      m0_d1   <= ha - hb;
      m0_w2   <= in_quad.fz;
      m0_d2   <= hd - hb;
    end
    m0_clamped <= in_quad.clamped;

    m1_p1      <= $signed({1'b0, m0_w1}) * m0_d1;
    m1_p2      <= $signed({1'b0, m0_w2}) * m0_d2;
    m1_base    <= m0_base;
    m1_clamped <= m0_clamped;

    m2_sum     <= $signed({{(SUM_W - HB - FB){1'b0}}, m1_base, {FB{1'b0}}})
                + $signed({{(SUM_W - PROD_W){m1_p1[PROD_W-1]}}, m1_p1})
                + $signed({{(SUM_W - PROD_W){m1_p2[PROD_W-1]}}, m1_p2});
    m2_clamped <= m1_clamped;
  end

  assign rounded = m2_sum + $signed(ROUND_HALF);
  assign quot    = rounded[SUM_W-1:FB];

  always_comb begin
    out_res.out_of_range = m2_clamped;
    if (m2_sum[SUM_W-1]) begin
      out_res.height = '0;
    end else if (|quot[Q_W-1:HB]) begin
      out_res.height = '1;
    end else begin
      out_res.height = quot[HB-1:0];
    end
  end

  assign out_valid = m2_valid;

endmodule

// ----- rtl/hftq_back.sv -----
// Back end: height memory, corner read sequencer, interpolation and result queue.
module hftq_back #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  hftq_pkg::cmd_t cmd_head,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output logic           res_valid,
  input  logic           res_stall,
  output hftq_pkg::res_t res_data
);

  localparam int HB     = hftq_pkg::HEIGHT_BITS;
  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int HELD_W = $clog2(hftq_pkg::RES_DEPTH + 1);

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } seq_state_t;

  seq_state_t             state, state_next;
  logic [1:0]             phase;
  logic [AW-1:0]          head_addr;
  logic [AW-1:0]          mem_addr;
  logic                   mem_we;
  logic [HB-1:0]          mem [DEPTH];
  logic [HB-1:0]          rd_data;
  logic                   rd_valid;
  logic [1:0]             rd_corner;
  logic                   issue;
  logic [1:0]             issue_corner;

  logic [AW-1:0]          job_base;
  logic [hftq_pkg::FRAC_W-1:0] job_fx, job_fz;
  logic                   job_clamped;
  logic [HB-1:0]          corner_a, corner_b, corner_c;

  logic [HELD_W-1:0]      res_held;
  logic                   res_room;
  logic                   start_query;
  logic                   res_accept;
  logic                   res_empty;

  logic                   quad_valid;
  hftq_pkg::quad_t        quad;
  logic                   interp_valid;
  hftq_pkg::res_t         interp_res;

  assign head_addr = AW'(int'(cmd_head.row) * MAX_COLUMNS + int'(cmd_head.col));
  assign res_room  = (res_held < HELD_W'(hftq_pkg::RES_DEPTH));

  always_comb begin
    cmd_pop      = 1'b0;
    start_query  = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = head_addr;
    issue        = 1'b0;
    issue_corner = CORNER_A;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty && (!cmd_head.is_query || res_room)) begin
          cmd_pop = 1'b1;
          if (cmd_head.is_query) begin
            start_query = 1'b1;
            issue       = 1'b1;
            state_next  = ST_READ;
          end else begin
            mem_we = cmd_head.keep;
          end
        end
      end
      ST_READ: begin
        issue        = 1'b1;
        issue_corner = phase;
        case (phase)
          CORNER_B: mem_addr = job_base + AW'(1);
          CORNER_C: mem_addr = job_base + AW'(MAX_COLUMNS);
          default:  mem_addr = job_base + AW'(MAX_COLUMNS + 1);
        endcase
        if (phase == CORNER_D) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_head.wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= CORNER_B;
      rd_valid  <= 1'b0;
      res_held  <= '0;
    end else begin
      state     <= state_next;
      rd_valid  <= issue;
      res_held  <= res_held + HELD_W'(start_query) - HELD_W'(res_accept);
      if (start_query) begin
        phase <= CORNER_B;
      end else if (state == ST_READ) begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_corner <= issue_corner;
    if (start_query) begin
      job_base    <= head_addr;
      job_fx      <= cmd_head.fx;
      job_fz      <= cmd_head.fz;
      job_clamped <= cmd_head.clamped;
    end
    if (rd_valid) begin
      case (rd_corner)
        CORNER_A: corner_a <= rd_data;
        CORNER_B: corner_b <= rd_data;
        CORNER_C: corner_c <= rd_data;
        default: ;
      endcase
    end
  end

  // The fourth corner goes straight into the pipeline while the job registers still hold.
  assign quad_valid   = rd_valid && (rd_corner == CORNER_D);
  assign quad.a       = corner_a;
  assign quad.b       = corner_b;
  assign quad.c       = corner_c;
  assign quad.d       = rd_data;
  assign quad.fx      = job_fx;
  assign quad.fz      = job_fz;
  assign quad.clamped = job_clamped;

  hftq_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quad_valid),
    .in_quad   (quad),
    .out_valid (interp_valid),
    .out_res   (interp_res)
  );

  assign res_valid  = !res_empty;
  assign res_accept = res_valid && !res_stall;

  hftq_fifo #(
    .DEPTH   (hftq_pkg::RES_DEPTH),
    .entry_t (hftq_pkg::res_t)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (interp_valid),
    .push_data (interp_res),
    .pop       (res_accept),
    .head      (res_data),
    .empty     (res_empty)
  );

endmodule

// ----- rtl/heightfield_triangle_height_query.sv -----
// Top level of the height-field triangle height query block.
//
// Usage: a request on the req channel either writes one height entry
// (mode write) or asks for the terrain height at a world X,Z position
// (mode query). A write gives no result; each query gives exactly one
// result on the res channel, in request order. Both channels move an item
// at a rising edge where valid is high and stall is low.
// A write takes one access of the height memory and a query four, since
// its four corner heights come from one single-port memory, one read a
// cycle; the next command waits until those reads are done, and writes go
// one per cycle while no query holds the memory.
// Configuration is written through cfg_we, cfg_index and cfg_data, one
// register per cycle; the user must write it only while no request is in
// flight, and the block itself does not enforce this.
// Reset clears the queues and the pipelines and loads the register reset
// values; the height memory is not cleared and must be written before it
// is queried. When res_stall is held, results collect in a small queue,
// then queries stop at the memory, and finally req_stall rises once the
// front end's count reaches the command queue depth; nothing is lost.
module heightfield_triangle_height_query #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  hftq_pkg::req_t                     req_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output hftq_pkg::res_t                     res_data,
  input  logic                               cfg_we,
  input  logic [hftq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hftq_pkg::CFG_W-1:0]         cfg_data
);

  // Configuration registers. The user must change them only while the block
  // is idle; the block does not enforce it. The front end reads them directly.
  hftq_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_columns      <= hftq_pkg::NUM_COLUMNS_RESET;
      cfg.num_rows         <= hftq_pkg::NUM_ROWS_RESET;
      cfg.half_width       <= hftq_pkg::HALF_WIDTH_RESET;
      cfg.half_length      <= hftq_pkg::HALF_LENGTH_RESET;
      cfg.inv_cell_spacing <= hftq_pkg::INV_CELL_SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hftq_pkg::CFG_NUM_COLUMNS: begin
          cfg.num_columns <= cfg_data[hftq_pkg::CNT_W-1:0];
        end
        hftq_pkg::CFG_NUM_ROWS: begin
          cfg.num_rows <= cfg_data[hftq_pkg::CNT_W-1:0];
        end
        hftq_pkg::CFG_HALF_WIDTH: begin
          cfg.half_width <= cfg_data[hftq_pkg::HALF_W-1:0];
        end
        hftq_pkg::CFG_HALF_LENGTH: begin
          cfg.half_length <= cfg_data[hftq_pkg::HALF_W-1:0];
        end
        hftq_pkg::CFG_INV_CELL_SPACING: begin
          cfg.inv_cell_spacing <= cfg_data[hftq_pkg::INV_W-1:0];
        end
        default: begin
          // Indexes past the last register are ignored.
        end
      endcase
    end
  end

  // The front end classifies each request and turns a query position into
  // a cell and a fraction per axis. It keeps a count of the requests it
  // holds plus those in the command queue, and stalls the request channel
  // when that count reaches the queue depth, so the queue never overflows.
  logic           cmd_push;
  hftq_pkg::cmd_t cmd_in;
  logic           cmd_pop;
  hftq_pkg::cmd_t cmd_head;
  logic           cmd_empty;

  hftq_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_pop   (cmd_pop)
  );

  // The command queue decouples the front end from the memory sequencer;
  // writes and queries leave it in order, so a query always sees every
  // write that came before it.
  hftq_fifo #(
    .DEPTH   (hftq_pkg::CMD_DEPTH),
    .entry_t (hftq_pkg::cmd_t)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  // The back end owns the height memory. It starts a query only when the
  // result queue has a free place reserved for it.
  hftq_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the height-field triangle height query block.
module tb_top;

  localparam int FRAC_BITS = hftq_pkg::FRAC_BITS;
  localparam int HEIGHT_BITS = hftq_pkg::HEIGHT_BITS;
  localparam int POS_W = hftq_pkg::POS_W;
  localparam int ENTRY_W = hftq_pkg::ENTRY_W;
  localparam int CNT_W = hftq_pkg::CNT_W;
  localparam int HALF_W = hftq_pkg::HALF_W;
  localparam int INV_W = hftq_pkg::INV_W;
  localparam int CFG_W = hftq_pkg::CFG_W;
  localparam int CFG_IDX_W = hftq_pkg::CFG_IDX_W;

  typedef hftq_pkg::req_t req_t;
  typedef hftq_pkg::res_t res_t;

  // The block is built with its default grid size; the predictor uses the same.
  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 128;
  localparam longint UNIT = longint'(1) << FRAC_BITS;

  // Settling time after the last result: a write gives no result, so the
  // block may still be busy with one.
  localparam int DRAIN_CYCLES = 24;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENT_ITEMS = 7;
  localparam int HOLD_ITEMS = 20;
  localparam int RUN_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Copy of the configuration registers, as the block should hold them.
  logic [CNT_W-1:0] cols_reg = hftq_pkg::NUM_COLUMNS_RESET;
  logic [CNT_W-1:0] rows_reg = hftq_pkg::NUM_ROWS_RESET;
  logic [HALF_W-1:0] half_w_reg = hftq_pkg::HALF_WIDTH_RESET;
  logic [HALF_W-1:0] half_l_reg = hftq_pkg::HALF_LENGTH_RESET;
  logic [INV_W-1:0] inv_reg = hftq_pkg::INV_CELL_SPACING_RESET;

  // The predicted height store, updated as write requests are accepted, and
  // a record of which entries the stimulus has written so far. Queries are
  // only generated once all four corners of their cell have been written.
  logic [HEIGHT_BITS-1:0] height_map[GRID_COLS*GRID_ROWS];
  bit entry_written[GRID_COLS*GRID_ROWS];

  req_t pending_reqs[$];
  res_t expected_heights[$];

  int reqs_queued = 0;
  int reqs_accepted = 0;
  int writes_seen = 0;
  int queries_checked = 0;
  int flagged_results = 0;
  int mismatch_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic req_took = 1'b0;

  int last_col = 0;
  int last_row = 0;

  heightfield_triangle_height_query #(
    .MAX_COLUMNS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Counts below 2 behave as 2, counts beyond the store behave as its size.
  function automatic int effective_count(input logic [CNT_W-1:0] v, input int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Maps one axis of a world position onto the grid: the cell index and the
  // fraction inside it, with 24 fraction bits, clamped to the grid, with a flag on clamping.
  function automatic void grid_locate(input longint pos, input longint half,
                                      input longint inv, input int count,
                                      output int cell_idx, output longint frac,
                                      output bit clamped);
    longint p;
    longint top;
    longint c;
    p = (pos + half) * inv;
    top = longint'(count - 1) << FRAC_BITS;
    clamped = 1'b0;
    if (p < 0) begin
      p = 0;
      clamped = 1'b1;
    end else if (p > top) begin
      p = top;
      clamped = 1'b1;
    end
    c = p >>> FRAC_BITS;
    if (c > count - 2) c = count - 2;
    cell_idx = int'(c);
    frac = p - (c << FRAC_BITS);
  endfunction

  // Expected result of one query under the current register settings. The
  // quad is split along the diagonal from (col,row) to (col+1,row+1); a
  // point exactly on the diagonal goes to the lower-right triangle.
  function automatic res_t terrain_height(input req_t rq);
    int cx;
    int cz;
    longint fx;
    longint fz;
    longint a;
    longint b;
    longint c;
    longint d;
    longint sum;
    longint r;
    bit flx;
    bit flz;
    res_t out;
    grid_locate($signed(rq.query_x), half_w_reg, inv_reg,
                effective_count(cols_reg, GRID_COLS), cx, fx, flx);
    grid_locate($signed(rq.query_z), half_l_reg, inv_reg,
                effective_count(rows_reg, GRID_ROWS), cz, fz, flz);
    a = height_map[cz * GRID_COLS + cx];
    b = height_map[cz * GRID_COLS + cx + 1];
    c = height_map[(cz + 1) * GRID_COLS + cx];
    d = height_map[(cz + 1) * GRID_COLS + cx + 1];
    if (fx < fz) sum = c * UNIT + fx * (d - c) + (UNIT - fz) * (a - c);
    else sum = b * UNIT + (UNIT - fx) * (a - b) + fz * (d - b);
    if (sum < 0) sum = 0;
    // Round half up, then saturate to the height range.
    r = (sum + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > (longint'(1) << HEIGHT_BITS) - 1) r = (longint'(1) << HEIGHT_BITS) - 1;
    out.height = r[HEIGHT_BITS-1:0];
    out.out_of_range = flx | flz;
    return out;
  endfunction

  // Heights lean on the two extremes so that the steepest slopes show up.
  function automatic logic [HEIGHT_BITS-1:0] rand_height();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return HEIGHT_BITS'($urandom);
  endfunction

  // Picks one coordinate of a query position. Most land on the grid, some
  // just past either edge, and the rest anywhere in the signed range.
  function automatic logic signed [POS_W-1:0] pick_position(input longint half,
                                                            input longint inv,
                                                            input int count);
    longint span;
    longint local_pos;
    longint p;
    int sel;
    sel = $urandom_range(99);
    if (inv == 0) span = longint'(1) << 16;
    else span = (longint'(count - 1) << FRAC_BITS) / inv;
    if (span > (longint'(1) << 25)) span = longint'(1) << 25;
    if (sel < 70) begin
      local_pos = longint'($urandom_range(int'(span)));
    end else if (sel < 85) begin
      if ($urandom_range(1)) local_pos = span + longint'($urandom_range(1, 600));
      else local_pos = -longint'($urandom_range(1, 600));
    end else begin
      return POS_W'($urandom);
    end
    p = local_pos - half;
    if (p > (longint'(1) << (POS_W - 1)) - 1) p = (longint'(1) << (POS_W - 1)) - 1;
    if (p < -(longint'(1) << (POS_W - 1))) p = -(longint'(1) << (POS_W - 1));
    return p[POS_W-1:0];
  endfunction

  // A write request; the position fields carry noise, which the block ignores.
  task automatic queue_height_write(input int col, input int row,
                                    input logic [HEIGHT_BITS-1:0] h);
    req_t rq;
    rq.mode = hftq_pkg::MODE_WRITE;
    rq.entry_column = ENTRY_W'(col);
    rq.entry_row = ENTRY_W'(row);
    rq.entry_height = h;
    rq.query_x = POS_W'($urandom);
    rq.query_z = POS_W'($urandom);
    entry_written[row * GRID_COLS + col] = 1'b1;
    pending_reqs.push_back(rq);
    reqs_queued++;
  endtask

  // A query request. Any corner of its cell that has never been written is
  // written first, so no query ever reads an undefined entry.
  task automatic queue_height_query(input logic signed [POS_W-1:0] x,
                                    input logic signed [POS_W-1:0] z);
    req_t rq;
    int cx;
    int cz;
    longint fx;
    longint fz;
    bit flx;
    bit flz;
    grid_locate(x, half_w_reg, inv_reg, effective_count(cols_reg, GRID_COLS), cx, fx, flx);
    grid_locate(z, half_l_reg, inv_reg, effective_count(rows_reg, GRID_ROWS), cz, fz, flz);
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        if (!entry_written[(cz + dr) * GRID_COLS + cx + dc])
          queue_height_write(cx + dc, cz + dr, rand_height());
      end
    end
    last_col = cx;
    last_row = cz;
    rq.mode = hftq_pkg::MODE_QUERY;
    rq.entry_column = ENTRY_W'($urandom);
    rq.entry_row = ENTRY_W'($urandom);
    rq.entry_height = HEIGHT_BITS'($urandom);
    rq.query_x = x;
    rq.query_z = z;
    pending_reqs.push_back(rq);
    reqs_queued++;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Applies an accepted request to the predicted store, or predicts its result.
  task automatic apply_request(input req_t rq);
    if (rq.mode == hftq_pkg::MODE_WRITE) begin
      height_map[int'(rq.entry_row) * GRID_COLS + int'(rq.entry_column)] = rq.entry_height;
      writes_seen++;
    end else begin
      expected_heights.push_back(terrain_height(rq));
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_heights.size() == 0) begin
      report_mismatch($sformatf("height %0d flag %0b came with no query outstanding",
                                got.height, got.out_of_range));
    end else begin
      want = expected_heights.pop_front();
      queries_checked++;
      if (want.out_of_range) flagged_results++;
      if (got.height !== want.height)
        report_mismatch($sformatf("query %0d height %0d, expected %0d",
                                  queries_checked, got.height, want.height));
      if (got.out_of_range !== want.out_of_range)
        report_mismatch($sformatf("query %0d out_of_range %0b, expected %0b",
                                  queries_checked, got.out_of_range, want.out_of_range));
    end
  endtask

  // Request driver. A new request goes out only when the held one was taken
  // at the last rising edge, so a stalled payload never changes.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_data <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver. Besides random stalls, it can hold off for a long run of
  // cycles so the block fills up and stalls its request channel.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    req_took <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        reqs_accepted++;
        apply_request(req_data);
      end
      if (res_valid && !res_stall) check_result(res_data);
    end
  end

  // Waits until every queued request is taken and every result is back, then
  // lets the block settle. The wait is bounded; leftovers are caught later.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    while ((reqs_accepted != reqs_queued || expected_heights.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      hftq_pkg::CFG_NUM_COLUMNS: cols_reg = value[CNT_W-1:0];
      hftq_pkg::CFG_NUM_ROWS: rows_reg = value[CNT_W-1:0];
      hftq_pkg::CFG_HALF_WIDTH: half_w_reg = value[HALF_W-1:0];
      hftq_pkg::CFG_HALF_LENGTH: half_l_reg = value[HALF_W-1:0];
      hftq_pkg::CFG_INV_CELL_SPACING: inv_reg = value[INV_W-1:0];
      default: ;
    endcase
  endtask

  // A burst of random requests under one idle profile. Most are queries,
  // some rewrite a corner of the last queried cell, a few write anywhere.
  task automatic run_segment(input int sender_pct, input int receiver_pct,
                             input int count, input bit with_hold);
    int sel;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        queue_height_write($urandom_range(GRID_COLS - 1), $urandom_range(GRID_ROWS - 1),
                           rand_height());
      end else if (sel < 25) begin
        queue_height_write(last_col + $urandom_range(1), last_row + $urandom_range(1),
                           rand_height());
      end else begin
        queue_height_query(
          pick_position(half_w_reg, inv_reg, effective_count(cols_reg, GRID_COLS)),
          pick_position(half_l_reg, inv_reg, effective_count(rows_reg, GRID_ROWS)));
      end
    end
    if (with_hold) hold_requests++;
    while (pending_reqs.size() != 0) @(negedge clk);
  endtask

  // One terrain setting: drain, write all registers (noise in the unused
  // upper data bits), then run the three idle profiles in turn.
  task automatic run_phase(input logic [CNT_W-1:0] cols, input logic [CNT_W-1:0] rows,
                           input logic [HALF_W-1:0] hw, input logic [HALF_W-1:0] hl,
                           input logic [INV_W-1:0] inv, input bit poke_unused,
                           input bit with_hold);
    logic [CFG_W-1:0] noise;
    noise = CFG_W'($urandom);
    wait_for_drain();
    write_register(hftq_pkg::CFG_NUM_COLUMNS, {noise[CFG_W-1:CNT_W], cols});
    write_register(hftq_pkg::CFG_NUM_ROWS, {noise[CFG_W-CNT_W-1:0], rows});
    write_register(hftq_pkg::CFG_HALF_WIDTH, {noise[0], hw});
    write_register(hftq_pkg::CFG_HALF_LENGTH, {noise[1], hl});
    write_register(hftq_pkg::CFG_INV_CELL_SPACING, inv);
    // Indexes past the last register must leave every setting alone.
    if (poke_unused) begin
      for (int k = int'(hftq_pkg::CFG_INV_CELL_SPACING) + 1; k < (1 << CFG_IDX_W); k++)
        write_register(CFG_IDX_W'(k), CFG_W'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    run_segment(36, 60, SEGMENT_ITEMS, 1'b0);
    run_segment(60, 36, SEGMENT_ITEMS, 1'b0);
    run_segment(0, 0, with_hold ? HOLD_ITEMS : SEGMENT_ITEMS, with_hold);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: one cell per world unit, grid
    // origin at world zero, so 256 position steps make one cell. Corners of
    // the first and last cells get the height extremes.
    queue_height_write(0, 0, '0);
    queue_height_write(1, 0, '1);
    queue_height_write(0, 1, '1);
    queue_height_write(1, 1, '0);
    queue_height_write(126, 126, '1);
    queue_height_write(127, 126, '1);
    queue_height_write(126, 127, '1);
    queue_height_write(127, 127, '1);
    // Grid origin, then the lower-right triangle, the upper-left triangle
    // and a point right on the diagonal.
    queue_height_query(24'sd0, 24'sd0);
    queue_height_query(24'sd128, 24'sd64);
    queue_height_query(24'sd64, 24'sd192);
    queue_height_query(24'sd128, 24'sd128);
    queue_height_query(24'sd1, 24'sd255);
    // Exactly on the far edge: last cell, full fraction, no flag.
    queue_height_query(24'sd32512, 24'sd32512);
    // Just beyond the far edge, and just below zero: both clamp and flag.
    queue_height_query(24'sd32513, 24'sd100);
    queue_height_query(-24'sd1, 24'sd0);
    // The extremes of the signed position range on both axes.
    queue_height_query(-24'sd8388608, 24'sd8388607);
    queue_height_query(24'sd8388607, -24'sd8388608);

    // Random part over a range of terrain settings: reset values, the
    // smallest grid, counts below their range with zero spacing, counts above
    // it with the largest width offset and spacing, and some arbitrary ones.
    run_phase(hftq_pkg::NUM_COLUMNS_RESET, hftq_pkg::NUM_ROWS_RESET,
              hftq_pkg::HALF_WIDTH_RESET, hftq_pkg::HALF_LENGTH_RESET,
              hftq_pkg::INV_CELL_SPACING_RESET, 1'b0, 1'b1);
    run_phase(8'd2, 8'd2, 23'h000100, 23'h000000, 24'h010000, 1'b0, 1'b0);
    run_phase(8'd0, 8'd1, 23'h7FFFFF, 23'h000000, 24'h000000, 1'b1, 1'b0);
    run_phase(8'd255, 8'd200, 23'h7FFFFF, 23'h400000, 24'hFFFFFF, 1'b0, 1'b0);
    run_phase(8'd128, 8'd128, 23'h004000, 23'h002000, 24'h020000, 1'b0, 1'b1);
    run_phase(CNT_W'($urandom_range(2, GRID_COLS)), CNT_W'($urandom_range(2, GRID_ROWS)),
              HALF_W'($urandom), HALF_W'($urandom), INV_W'($urandom_range(1, 24'hFFFFFF)),
              1'b1, 1'b0);
    run_phase(8'd3, 8'd17, HALF_W'($urandom), HALF_W'($urandom), 24'h000001, 1'b0, 1'b0);

    wait_for_drain();
    if (expected_heights.size() != 0)
      report_mismatch($sformatf("%0d query results never arrived", expected_heights.size()));

    $display("Run covered %0d requests: %0d height writes and %0d checked queries.",
             reqs_accepted, writes_seen, queries_checked);
    $display("Seven terrain settings, %0d clamped positions, %0d mismatches.",
             flagged_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("heightfield_triangle_height_query verification clean");
    end else begin
      $display("heightfield_triangle_height_query verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("heightfield_triangle_height_query verification failed");
    $finish;
  end

endmodule
